// ===== src/tdfa_pkg.sv =====
package tdfa_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned STATE_W = 4;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned LIM_W   = 9;
  localparam int unsigned MARKS   = 16;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_STATES_IN_USE = 1'b0;
  localparam logic REG_START_STATE   = 1'b1;

  // Input item actions.
  typedef enum logic [1:0] {
    ACT_ADD_TRANS = 2'd0,
    ACT_SET_MARK  = 2'd1,
    ACT_FEED      = 2'd2,
    ACT_JUDGE     = 2'd3
  } action_t;

  // Configuration registers as seen by the datapath.
  typedef struct packed {
    logic [4:0]         states_in_use;
    logic [STATE_W-1:0] start_state;
  } cfg_regs_t;

  // One transition table entry.
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] next;
  } tbl_entry_t;

  // A state index is usable when it lies below the effective limit.
  function automatic logic st_ok(input logic [STATE_W-1:0] s, input logic [LIM_W-1:0] lim);
    st_ok = {{(LIM_W-STATE_W){1'b0}}, s} < lim;
  endfunction

endpackage

// ===== src/tdfa_ram.sv =====
module tdfa_ram #(
  parameter int unsigned WIDTH = 5,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read that holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tdfa_cfg.sv =====
module tdfa_cfg
  import tdfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign regs   = regs_r;

  // Register write decode.
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      case (paddr[2])
        REG_STATES_IN_USE: regs_nxt.states_in_use = pwdata[4:0];
        REG_START_STATE:   regs_nxt.start_state   = pwdata[STATE_W-1:0];
        default:           regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.states_in_use <= 5'd16;
      regs_r.start_state   <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (paddr[2])
      REG_STATES_IN_USE: prdata = {27'd0, regs_r.states_in_use};
      REG_START_STATE:   prdata = {28'd0, regs_r.start_state};
      default:           prdata = '0;
    endcase
  end

endmodule

// ===== src/table_driven_dfa_acceptor.sv =====
// Programmable byte-symbol automaton. The transition table (valid bit and next
// state per state and byte) lives in one RAM with a write port and a read port,
// STATES*256 entries with a registered read; accepting marks are flip-flops.
// After reset a clearing pass writes every table entry invalid, one per cycle,
// and the block accepts no item until it ends; configuration writes are taken
// throughout. Afterwards a transition or mark load is written straight from
// idle, a non-final symbol passes through the table read (ST_LOOK) that yields
// the next state, and an item that yields a result passes through the result
// stage (ST_RESP) as well, so a final symbol goes through ST_LOOK and ST_RESP
// and an empty-text judgment or a rejected load through ST_RESP alone. The
// output register lets the next item enter while a result waits to be taken.
module table_driven_dfa_acceptor
  import tdfa_pkg::*;
#(
  parameter int unsigned STATES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input channel.
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   in_action,
  input  logic [3:0]   in_state_index,
  input  logic [7:0]   in_symbol,
  input  logic [3:0]   in_target_state,
  input  logic         in_final_flag,
  input  logic         in_last,
  // Result channel.
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_accepted,
  output logic         out_status,
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned DEPTH = STATES * 256;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned EW    = $bits(tbl_entry_t);
  localparam logic [LIM_W-1:0] STATES_L = LIM_W'(STATES);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CLEAR = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_RESP  = 4'b1000
  } fsm_t;

  cfg_regs_t          cfg;
  fsm_t               st_r, st_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [STATE_W-1:0] cur_r, cur_nxt;
  logic               rej_r, rej_nxt;
  logic               mid_r, mid_nxt;
  logic               look_r, look_nxt;
  logic               last_r, last_nxt;
  logic               res_acc_r, res_acc_nxt;
  logic               res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_acc_r, out_acc_nxt;
  logic               out_st_r, out_st_nxt;
  logic [MARKS-1:0]   marks_r;
  logic               mark_we;

  logic [LIM_W-1:0]   lim;
  logic               accept;
  logic [STATE_W-1:0] cur_eff;
  logic               rej_eff;
  logic               cur_ok;
  logic [7:0]         src8;
  logic [7:0]         cur8;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [EW-1:0]      ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [EW-1:0]      ram_rdata;
  tbl_entry_t         rd_ent;
  tbl_entry_t         wr_ent;
  logic [STATE_W-1:0] l_cur;
  logic               l_rej;

  tdfa_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (cfg)
  );

  tdfa_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Effective state limit is the smaller of the register and the table size.
  assign lim = ({4'd0, cfg.states_in_use} < STATES_L) ? {4'd0, cfg.states_in_use} : STATES_L;

  assign in_ready     = (st_r == ST_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_status   = out_st_r;

  // A symbol outside a text starts a new one from the start state.
  assign cur_eff = mid_r ? cur_r : cfg.start_state;
  assign rej_eff = mid_r ? rej_r : 1'b0;
  assign cur_ok  = st_ok(cur_eff, lim);

  // Table addressing: state bits above the byte symbol.
  assign src8      = {4'd0, in_state_index};
  assign cur8      = {4'd0, cur_eff};
  assign ram_raddr = AW'({cur8, in_symbol});
  assign ram_waddr = (st_r == ST_CLEAR) ? clr_cnt_r : AW'({src8, in_symbol});
  assign wr_ent.valid = (st_r != ST_CLEAR);
  assign wr_ent.next  = in_target_state;
  assign ram_wdata = wr_ent;
  assign rd_ent    = tbl_entry_t'(ram_rdata);

  // Result of the lookup that was issued when the symbol was accepted.
  always_comb begin
    l_cur = cur_r;
    l_rej = rej_r;
    if (look_r) begin
      if (rd_ent.valid) begin
        l_cur = rd_ent.next;
        l_rej = !st_ok(rd_ent.next, lim);
      end else begin
        l_rej = 1'b1;
      end
    end
  end

  // Sequencer next state.
  always_comb begin
    st_nxt      = st_r;
    clr_cnt_nxt = clr_cnt_r;
    cur_nxt     = cur_r;
    rej_nxt     = rej_r;
    mid_nxt     = mid_r;
    look_nxt    = look_r;
    last_nxt    = last_r;
    res_acc_nxt = res_acc_r;
    res_st_nxt  = res_st_r;
    out_acc_nxt = out_acc_r;
    out_st_nxt  = out_st_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    mark_we     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    case (st_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(in_action))
            ACT_ADD_TRANS: begin
              if (st_ok(in_state_index, lim) && st_ok(in_target_state, lim)) begin
                ram_we = 1'b1;
              end else begin
                res_acc_nxt = 1'b0;
                res_st_nxt  = 1'b1;
                st_nxt      = ST_RESP;
              end
            end
            ACT_SET_MARK: begin
              if (st_ok(in_state_index, lim)) begin
                mark_we = 1'b1;
              end else begin
                res_acc_nxt = 1'b0;
                res_st_nxt  = 1'b1;
                st_nxt      = ST_RESP;
              end
            end
            ACT_JUDGE: begin
              mid_nxt     = 1'b0;
              rej_nxt     = 1'b0;
              cur_nxt     = cfg.start_state;
              res_st_nxt  = !st_ok(cfg.start_state, lim);
              res_acc_nxt = st_ok(cfg.start_state, lim) && marks_r[cfg.start_state];
              st_nxt      = ST_RESP;
            end
            ACT_FEED: begin
              mid_nxt  = 1'b1;
              cur_nxt  = cur_eff;
              rej_nxt  = rej_eff || !cur_ok;
              look_nxt = !rej_eff && cur_ok;
              ram_re   = !rej_eff && cur_ok;
              last_nxt = in_last;
              st_nxt   = ST_LOOK;
            end
            default: st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOOK: begin
        cur_nxt = l_cur;
        rej_nxt = l_rej;
        if (last_r) begin
          mid_nxt     = 1'b0;
          rej_nxt     = 1'b0;
          res_st_nxt  = !st_ok(l_cur, lim);
          res_acc_nxt = !l_rej && st_ok(l_cur, lim) && marks_r[l_cur];
          st_nxt      = ST_RESP;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = res_acc_r;
          out_st_nxt    = res_st_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cur_r       <= '0;
      rej_r       <= 1'b0;
      mid_r       <= 1'b0;
      look_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      marks_r     <= '0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      cur_r       <= cur_nxt;
      rej_r       <= rej_nxt;
      mid_r       <= mid_nxt;
      look_r      <= look_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      if (mark_we) begin
        marks_r[in_state_index] <= in_final_flag;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    res_acc_r <= res_acc_nxt;
    res_st_r  <= res_st_nxt;
    out_acc_r <= out_acc_nxt;
    out_st_r  <= out_st_nxt;
  end

  // A symbol beat always moves on to the table lookup.
  a_feed_looks: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == ACT_FEED) |=> st_r == ST_LOOK)
    else $error("symbol beat did not start a lookup");

  // The table is never written while a lookup result is pending.
  a_no_write_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_LOOK |-> !ram_we)
    else $error("table write during lookup");

  // An accepting verdict always carries status ok.
  a_acc_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_acc_r && out_st_r))
    else $error("accepted with invalid status");

  // The clearing pass ends only after the last table entry.
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    $past(st_r) == ST_CLEAR && st_r == ST_IDLE |-> $past(clr_cnt_r) == LAST_ADDR)
    else $error("clearing pass ended early");

endmodule
